@@ rtl/core/stq_pkg.sv @@
// Package for the session table: sizes, operation and status codes,
// register indexes and the slot record type. No dependencies.
package stq_pkg;

  localparam int SLOTS  = 64;
  localparam int OWNERS = 1024;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int OWN_AW = $clog2(OWNERS);
  localparam int CNT_W  = 7;

  localparam logic [2:0] OP_LOGIN     = 3'd0;
  localparam logic [2:0] OP_LOGOUT    = 3'd1;
  localparam logic [2:0] OP_DROP      = 3'd2;
  localparam logic [2:0] OP_GET_OWNER = 3'd3;
  localparam logic [2:0] OP_GET_LANG  = 3'd4;
  localparam logic [2:0] OP_TICK      = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOTAL     = 3'd1;
  localparam logic [2:0] ST_OWNER     = 3'd2;
  localparam logic [2:0] ST_COLL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_COUNT     = 3'd5;

  localparam logic [1:0] CFG_MAX_TOTAL = 2'd0;
  localparam logic [1:0] CFG_MAX_OWNER = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [9:0]  owner;
    logic [7:0]  lang;
    logic [31:0] stamp;
  } slot_t;

endpackage

@@ rtl/core/stq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/stq_cell.sv @@
// One slot of the rotating session ring: takes its neighbour's record on
// a step, or a new record on a load. Depends on stq_pkg.
module stq_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  stq_pkg::slot_t nbr,
  input  logic          ld,
  input  stq_pkg::slot_t ld_data,
  output stq_pkg::slot_t q
);
  import stq_pkg::*;

  logic  valid_r;
  slot_t body_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= nbr.valid;
    end else if (ld) begin
      valid_r <= ld_data.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      body_r <= nbr;
    end else if (ld) begin
      body_r <= ld_data;
    end
  end

  always_comb begin
    q       = body_r;
    q.valid = valid_r;
  end

endmodule

@@ rtl/core/session_table_with_quotas.sv @@
// Session table with admission quotas and idle aging: slot ring, owner
// counter RAM and the sequencer. Depends on stq_pkg, stq_cell, stq_ram.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | op, owner_id, language, session_id
//  out_    | output    | out_valid/out_stall| status, new_id, found_owner,
//          |           |                    | found_language, evicted, open_count
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_addr, cfg_data
//
// Login, logout, drop and lookups rotate the 64-slot ring once, with an
// extra owner counter read for each session due for removal, and then pass
// through S_POST, S_DEC and S_FIN; the next request can be taken in the
// cycle the result appears. Tick and undefined ops go straight to S_FIN.
// After reset a clearing pass zeroes all 1024 owner counters;
// in_stall stays high meanwhile. Config writes are taken at any time.
// A held result (out_stall) blocks completion, not acceptance of one item.
module session_table_with_quotas (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [9:0]  in_owner_id,
  input  logic [7:0]  in_language,
  input  logic [31:0] in_session_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_new_id,
  output logic [9:0]  out_found_owner,
  output logic [7:0]  out_found_language,
  output logic [6:0]  out_evicted,
  output logic [6:0]  out_open_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  import stq_pkg::*;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_SCAN, S_CHK, S_POST, S_DEC, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic [OWN_AW-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [9:0]  own_r, own_nxt;
  logic [7:0]  lang_r, lang_nxt;
  logic [31:0] sid_r, sid_nxt;
  logic [31:0] clock_r, clock_nxt;
  logic [31:0] idc_r, idc_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] maxt_r, maxt_nxt, maxo_r, maxo_nxt;
  logic [15:0] tmo_r, tmo_nxt;
  logic failed_r, failed_nxt, found_r, found_nxt;
  logic free_found_r, free_found_nxt, coll_r, coll_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] newid_r, newid_nxt;
  logic [9:0]  fown_r, fown_nxt;
  logic [7:0]  flang_r, flang_nxt;
  logic [CNT_W-1:0] evict_r, evict_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic [31:0] o_newid_r, o_newid_nxt;
  logic [9:0]  o_fown_r, o_fown_nxt;
  logic [7:0]  o_flang_r, o_flang_nxt;
  logic [CNT_W-1:0] o_evict_r, o_evict_nxt, o_open_r, o_open_nxt;

  slot_t cell_q [SLOTS];
  slot_t head, head_wb, ld_data;
  logic  step, load;
  logic [SLOTS-1:0] valid_vec;

  logic              we;
  logic [OWN_AW-1:0] waddr, raddr;
  logic [CNT_W-1:0]  wdata, rdata;

  logic is_get, hit_id, need_rm, vld_after;
  logic [31:0] age;

  assign head = cell_q[0];

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      slot_t nbr;
      if (g == SLOTS - 1) begin : g_tail
        assign nbr = head_wb;
      end else begin : g_mid
        assign nbr = cell_q[g+1];
      end
      stq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .nbr     (nbr),
        .ld      (load && (free_idx_r == IDX_W'(g))),
        .ld_data (ld_data),
        .q       (cell_q[g])
      );
      assign valid_vec[g] = cell_q[g].valid;
    end
  endgenerate

  stq_ram #(.W(CNT_W), .D(OWNERS)) u_cnt (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign age    = clock_r - head.stamp;
  assign is_get = (op_r == OP_GET_OWNER) || (op_r == OP_GET_LANG);
  assign hit_id = head.valid && (head.id == sid_r) && !found_r &&
                  ((op_r == OP_LOGOUT) || is_get);
  assign need_rm = (head.valid && !failed_r && (op_r == OP_LOGIN) &&
                    (age > {16'd0, tmo_r})) ||
                   (head.valid && !failed_r && (op_r == OP_DROP) &&
                    (head.owner == own_r)) ||
                   (hit_id && (op_r == OP_LOGOUT));

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r; idx_nxt = idx_r;
    op_nxt = op_r; own_nxt = own_r; lang_nxt = lang_r; sid_nxt = sid_r;
    clock_nxt = clock_r; idc_nxt = idc_r; total_nxt = total_r;
    maxt_nxt = maxt_r; maxo_nxt = maxo_r; tmo_nxt = tmo_r;
    failed_nxt = failed_r; found_nxt = found_r;
    free_found_nxt = free_found_r; free_idx_nxt = free_idx_r; coll_nxt = coll_r;
    status_nxt = status_r; newid_nxt = newid_r; fown_nxt = fown_r;
    flang_nxt = flang_r; evict_nxt = evict_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_status_nxt = o_status_r; o_newid_nxt = o_newid_r; o_fown_nxt = o_fown_r;
    o_flang_nxt = o_flang_r; o_evict_nxt = o_evict_r; o_open_nxt = o_open_r;
    step = 1'b0; load = 1'b0; head_wb = head; vld_after = head.valid;
    we = 1'b0; waddr = OWN_AW'(own_r); wdata = '0; raddr = OWN_AW'(own_r);
    ld_data.valid = 1'b1; ld_data.id = idc_r; ld_data.owner = own_r;
    ld_data.lang = lang_r; ld_data.stamp = clock_r;

    if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_MAX_TOTAL: maxt_nxt = cfg_data[CNT_W-1:0];
        CFG_MAX_OWNER: maxo_nxt = cfg_data[CNT_W-1:0];
        CFG_TIMEOUT:   tmo_nxt  = cfg_data[15:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLR: begin
        we = 1'b1; waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == OWN_AW'(OWNERS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op; own_nxt = in_owner_id; lang_nxt = in_language;
          sid_nxt = in_session_id;
          failed_nxt = 1'b0; found_nxt = 1'b0; free_found_nxt = 1'b0;
          coll_nxt = 1'b0; status_nxt = ST_OK; newid_nxt = '0;
          fown_nxt = '0; flang_nxt = '0; evict_nxt = '0; idx_nxt = '0;
          if (in_op == OP_TICK) begin
            clock_nxt = clock_r + 32'd1;
            state_nxt = S_FIN;
          end else if (in_op > OP_TICK) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (need_rm) begin
          raddr = OWN_AW'(head.owner);
          state_nxt = S_CHK;
        end else begin
          step = 1'b1;
          if (hit_id && is_get) begin
            found_nxt = 1'b1; fown_nxt = head.owner; flang_nxt = head.lang;
            if (op_r == OP_GET_OWNER) head_wb.stamp = clock_r;
          end
        end
      end
      S_CHK: begin
        step = 1'b1;
        state_nxt = S_SCAN;
        if (op_r == OP_LOGOUT) found_nxt = 1'b1;
        if (rdata == '0) begin
          failed_nxt = 1'b1; status_nxt = ST_COUNT;
        end else begin
          we = 1'b1; waddr = OWN_AW'(head.owner); wdata = rdata - 1'b1;
          head_wb.valid = 1'b0; vld_after = 1'b0;
          if (total_r != '0) total_nxt = total_r - 1'b1;
          if (op_r != OP_LOGOUT) evict_nxt = evict_r + 1'b1;
        end
      end
      S_POST: state_nxt = S_DEC;  // owner counter read of the request owner
      S_DEC: begin
        state_nxt = S_FIN;
        if (op_r == OP_LOGIN) begin
          if (!failed_r) begin
            priority if (total_r >= maxt_r) status_nxt = ST_TOTAL;
            else if (rdata >= maxo_r) status_nxt = ST_OWNER;
            else if (!free_found_r) status_nxt = ST_TOTAL;
            else begin
              idc_nxt = (idc_r == 32'hFFFF_FFFF) ? 32'd1 : idc_r + 32'd1;
              if (coll_r) begin
                status_nxt = ST_COLL;
              end else begin
                load = 1'b1;
                we = 1'b1; wdata = rdata + 1'b1;
                total_nxt = total_r + 1'b1;
                newid_nxt = idc_r;
              end
            end
          end
        end else if (op_r == OP_DROP) begin
          if (!failed_r && rdata != '0) status_nxt = ST_COUNT;
        end else if (!found_r) begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_status_nxt = status_r; o_newid_nxt = newid_r; o_fown_nxt = fown_r;
          o_flang_nxt = flang_r; o_evict_nxt = evict_r; o_open_nxt = total_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // free slot and collision are judged on each slot as it leaves the head
    if (step) begin
      if (op_r == OP_LOGIN) begin
        if (!vld_after && !free_found_r) begin
          free_found_nxt = 1'b1; free_idx_nxt = idx_r;
        end
        if (vld_after && head.id == idc_r) coll_nxt = 1'b1;
      end
      idx_nxt = idx_r + 1'b1;
      if (idx_r == IDX_W'(SLOTS - 1)) state_nxt = S_POST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; idx_r <= '0;
      clock_r <= '0; idc_r <= 32'd1; total_r <= '0;
      maxt_r <= CNT_W'(64); maxo_r <= CNT_W'(64); tmo_r <= 16'd300;
      failed_r <= 1'b0; found_r <= 1'b0; free_found_r <= 1'b0; coll_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; idx_r <= idx_nxt;
      clock_r <= clock_nxt; idc_r <= idc_nxt; total_r <= total_nxt;
      maxt_r <= maxt_nxt; maxo_r <= maxo_nxt; tmo_r <= tmo_nxt;
      failed_r <= failed_nxt; found_r <= found_nxt;
      free_found_r <= free_found_nxt; coll_r <= coll_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; own_r <= own_nxt; lang_r <= lang_nxt; sid_r <= sid_nxt;
    free_idx_r <= free_idx_nxt; status_r <= status_nxt; newid_r <= newid_nxt;
    fown_r <= fown_nxt; flang_r <= flang_nxt; evict_r <= evict_nxt;
    o_status_r <= o_status_nxt; o_newid_r <= o_newid_nxt; o_fown_r <= o_fown_nxt;
    o_flang_r <= o_flang_nxt; o_evict_r <= o_evict_nxt; o_open_r <= o_open_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_new_id         = o_newid_r;
  assign out_found_owner    = o_fown_r;
  assign out_found_language = o_flang_r;
  assign out_evicted        = o_evict_r;
  assign out_open_count     = o_open_r;

  // ring is back in slot order whenever no request is in flight
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> idx_r == '0)
    else $error("slot ring not at home position while idle");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(valid_vec) == 32'(total_r))
    else $error("open count differs from occupied slots");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !cell_q[free_idx_r].valid && !step)
    else $error("new session loaded over an occupied slot");

endmodule

@@ verif/session_table_with_quotas_tb.sv @@
// Self-checking bench for session_table_with_quotas: queued requests, a
// request-by-request predictor of the slot table, and a field-by-field result check.
// Depends on stq_pkg and the session_table_with_quotas RTL.
module session_table_with_quotas_tb;
  import stq_pkg::*;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  owner;
    logic [7:0]  lang;
    logic [31:0] sid;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] new_id;
    logic [9:0]  f_owner;
    logic [7:0]  f_lang;
    logic [6:0]  evicted;
    logic [6:0]  open_cnt;
  } outcome_t;

  localparam logic [2:0] OP_UNDEF_A = 3'd6;
  localparam logic [2:0] OP_UNDEF_B = 3'd7;
  localparam int         STALL_LIMIT = 6000;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_op;
  logic [9:0] in_owner_id;
  logic [7:0] in_language;
  logic [31:0] in_session_id;
  logic out_valid, out_stall;
  logic [2:0] out_status;
  logic [31:0] out_new_id;
  logic [9:0] out_found_owner;
  logic [7:0] out_found_language;
  logic [6:0] out_evicted, out_open_count;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_addr;
  logic [31:0] cfg_data;

  session_table_with_quotas dut (.*);

  // predicted table state
  logic        tbl_valid [SLOTS];
  logic [31:0] tbl_id    [SLOTS];
  logic [9:0]  tbl_owner [SLOTS];
  logic [7:0]  tbl_lang  [SLOTS];
  logic [31:0] tbl_stamp [SLOTS];
  logic [6:0]  per_owner [OWNERS];
  logic [31:0] now_sec, next_id;
  logic [6:0]  open_total;
  logic [6:0]  lim_total, lim_owner;
  logic [15:0] timeout_s;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int tx_idle_pct = 0, rx_stall_pct = 0;
  bit req_taken = 0, cfg_taken = 0;
  int quiet_cycles = 0;
  int n_sent = 0, n_done = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int find_session(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic bit drop_slot(int i);
    if (per_owner[tbl_owner[i]] == 0) return 0;
    per_owner[tbl_owner[i]]--;
    tbl_valid[i] = 0;
    if (open_total > 0) open_total--;
    return 1;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    bit broken;
    int freeslot, s;
    logic [31:0] id;
    o = '0;
    broken = 0;
    freeslot = -1;
    case (r.op)
      OP_LOGIN: begin
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && (now_sec - tbl_stamp[i]) > {16'd0, timeout_s}) begin
            if (!drop_slot(i)) begin
              o.status = ST_COUNT;
              broken = 1;
              break;
            end
            o.evicted++;
          end
        if (!broken) begin
          for (int i = 0; i < SLOTS; i++)
            if (!tbl_valid[i]) begin
              freeslot = i;
              break;
            end
          if (open_total >= lim_total) o.status = ST_TOTAL;
          else if (per_owner[r.owner] >= lim_owner) o.status = ST_OWNER;
          else if (freeslot < 0) o.status = ST_TOTAL;
          else begin
            id = next_id;
            next_id++;
            if (next_id == 0) next_id = 1;
            if (find_session(id) >= 0) o.status = ST_COLL;
            else begin
              tbl_valid[freeslot] = 1;
              tbl_id[freeslot] = id;
              tbl_owner[freeslot] = r.owner;
              tbl_lang[freeslot] = r.lang;
              tbl_stamp[freeslot] = now_sec;
              per_owner[r.owner]++;
              open_total++;
              o.new_id = id;
            end
          end
        end
      end
      OP_LOGOUT: begin
        s = find_session(r.sid);
        if (s < 0) o.status = ST_NOT_FOUND;
        else if (!drop_slot(s)) o.status = ST_COUNT;
      end
      OP_DROP: begin
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && tbl_owner[i] == r.owner) begin
            if (!drop_slot(i)) begin
              o.status = ST_COUNT;
              break;
            end
            o.evicted++;
          end
        if (o.status == ST_OK && per_owner[r.owner] != 0) o.status = ST_COUNT;
      end
      OP_GET_OWNER, OP_GET_LANG: begin
        s = find_session(r.sid);
        if (s < 0) o.status = ST_NOT_FOUND;
        else begin
          o.f_owner = tbl_owner[s];
          o.f_lang = tbl_lang[s];
          if (r.op == OP_GET_OWNER) tbl_stamp[s] = now_sec;
        end
      end
      OP_TICK: now_sec++;
      default: ;
    endcase
    o.open_cnt = open_total;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // sampling, prediction and checking
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && in_valid && !in_stall) begin
      expected_outcomes.push_back(apply_request({in_op, in_owner_id, in_language,
                                                 in_session_id}));
      req_taken = 1;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_MAX_TOTAL: lim_total = cfg_data[6:0];
        CFG_MAX_OWNER: lim_owner = cfg_data[6:0];
        CFG_TIMEOUT:   timeout_s = cfg_data[15:0];
        default: ;
      endcase
      cfg_taken = 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_done++;
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        e = expected_outcomes.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_new_id !== e.new_id) report_mismatch("new_id", out_new_id, e.new_id);
        if (out_found_owner !== e.f_owner)
          report_mismatch("found_owner", out_found_owner, e.f_owner);
        if (out_found_language !== e.f_lang)
          report_mismatch("found_language", out_found_language, e.f_lang);
        if (out_evicted !== e.evicted) report_mismatch("evicted", out_evicted, e.evicted);
        if (out_open_count !== e.open_cnt)
          report_mismatch("open_count", out_open_count, e.open_cnt);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else if (++quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // request driver and result back-pressure
  always @(negedge clk) begin
    request_t r;
    logic nv;
    nv = in_valid;
    if (!rst_n) nv = 0;
    else begin
      if (req_taken) begin
        req_taken = 0;
        nv = 0;
      end
      if (!nv && pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        r = pending_reqs.pop_front();
        n_sent++;
        in_op <= r.op;
        in_owner_id <= r.owner;
        in_language <= r.lang;
        in_session_id <= r.sid;
        nv = 1;
      end
    end
    in_valid <= nv;
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  function automatic request_t mk(logic [2:0] op, logic [9:0] owner, logic [7:0] lang,
                                  logic [31:0] sid);
    return '{op: op, owner: owner, lang: lang, sid: sid};
  endfunction

  // mostly live IDs and a small owner pool so quotas and drops bite
  function automatic request_t random_request();
    request_t r;
    int pick;
    r.owner = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(5));
    r.lang = 8'($urandom);
    if ($urandom_range(9) == 0) r.sid = $urandom;
    else r.sid = (next_id > 8) ? $urandom_range(next_id, next_id - 8) : $urandom_range(9);
    pick = $urandom_range(99);
    if (pick < 35) r.op = OP_LOGIN;
    else if (pick < 47) r.op = OP_LOGOUT;
    else if (pick < 52) r.op = OP_DROP;
    else if (pick < 67) r.op = OP_GET_OWNER;
    else if (pick < 79) r.op = OP_GET_LANG;
    else if (pick < 97) r.op = OP_TICK;
    else r.op = $urandom_range(1) ? OP_UNDEF_A : OP_UNDEF_B;
    return r;
  endfunction

  // every request handed to the DUT has had its result checked
  task automatic drain();
    wait (pending_reqs.size() == 0 && n_done == n_sent);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_addr <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    cfg_taken = 0;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 0;
  endtask

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) begin
      wait (pending_reqs.size() < 4);
      pending_reqs.push_back(random_request());
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 0; tbl_id[i] = 0; tbl_owner[i] = 0; tbl_lang[i] = 0; tbl_stamp[i] = 0;
    end
    for (int i = 0; i < OWNERS; i++) per_owner[i] = 0;
    now_sec = 0; next_id = 1; open_total = 0;
    lim_total = 64; lim_owner = 64; timeout_s = 300;
    rst_n = 0; in_valid = 0; out_stall = 0; cfg_valid = 0; cfg_addr = 0; cfg_data = 0;
    in_op = 0; in_owner_id = 0; in_language = 0; in_session_id = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // directed: field extremes, every op, not-found and undefined ops
    pending_reqs.push_back(mk(OP_LOGIN, 10'd0, 8'd0, 32'd0));
    pending_reqs.push_back(mk(OP_LOGIN, 10'd1023, 8'd255, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(OP_GET_OWNER, 10'd0, 8'd0, 32'd2));
    pending_reqs.push_back(mk(OP_GET_LANG, 10'd0, 8'd0, 32'd1));
    pending_reqs.push_back(mk(OP_GET_LANG, 10'd0, 8'd0, 32'd0));
    pending_reqs.push_back(mk(OP_GET_OWNER, 10'd0, 8'd0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(OP_LOGOUT, 10'd0, 8'd0, 32'd1));
    pending_reqs.push_back(mk(OP_LOGOUT, 10'd0, 8'd0, 32'd1));
    pending_reqs.push_back(mk(OP_TICK, 10'd0, 8'd0, 32'd0));
    pending_reqs.push_back(mk(OP_UNDEF_A, 10'h3FF, 8'hFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(OP_UNDEF_B, 10'd0, 8'd0, 32'd0));
    pending_reqs.push_back(mk(OP_DROP, 10'd1023, 8'd0, 32'd0));
    pending_reqs.push_back(mk(OP_DROP, 10'd5, 8'd0, 32'd0));
    drain();

    // owner quota of one and total quota of two, then zero timeout so a tick ages everything
    write_reg(CFG_MAX_TOTAL, 32'd2);
    write_reg(CFG_MAX_OWNER, 32'd1);
    write_reg(CFG_TIMEOUT, 32'd0);
    pending_reqs.push_back(mk(OP_LOGIN, 10'd7, 8'd1, 32'd0));
    pending_reqs.push_back(mk(OP_LOGIN, 10'd7, 8'd2, 32'd0));
    pending_reqs.push_back(mk(OP_LOGIN, 10'd8, 8'd3, 32'd0));
    pending_reqs.push_back(mk(OP_LOGIN, 10'd9, 8'd4, 32'd0));
    pending_reqs.push_back(mk(OP_TICK, 10'd0, 8'd0, 32'd0));
    pending_reqs.push_back(mk(OP_LOGIN, 10'd9, 8'd5, 32'd0));
    drain();

    write_reg(CFG_MAX_TOTAL, 32'd0);
    pending_reqs.push_back(mk(OP_LOGIN, 10'd3, 8'd6, 32'd0));
    drain();

    // phase 1: sender idles lightly, receiver stalls heavily
    write_reg(CFG_MAX_TOTAL, 32'd64);
    write_reg(CFG_MAX_OWNER, 32'd0);
    write_reg(CFG_TIMEOUT, 32'd65535);
    tx_idle_pct = 29; rx_stall_pct = 73;
    run_random(20);
    drain();
    write_reg(CFG_MAX_OWNER, 32'd64);
    run_random(180);
    drain();

    // phase 2: roles swapped, total quota above the slot count so the table can run out of slots
    write_reg(CFG_MAX_TOTAL, 32'd100);
    write_reg(CFG_MAX_OWNER, 32'd40);
    write_reg(CFG_TIMEOUT, 32'd40);
    tx_idle_pct = 73; rx_stall_pct = 29;
    run_random(200);
    drain();

    // phase 3: full rate, tight limits and short timeout
    write_reg(CFG_MAX_TOTAL, 32'd12);
    write_reg(CFG_MAX_OWNER, 32'd3);
    write_reg(CFG_TIMEOUT, 32'd4);
    tx_idle_pct = 0; rx_stall_pct = 0;
    run_random(200);
    drain();

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
